/* rtl/core/page_table_walk_translate_top_assert.svh */
// Assertion macros shared by the translation table walker modules.
`ifndef PAGE_TABLE_WALK_TRANSLATE_TOP_ASSERT_SVH
`define PAGE_TABLE_WALK_TRANSLATE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTWT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page table walker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTWT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page table walker assertion failed");

`endif

/* rtl/core/ptwt_pkg.sv */
// Package with the types, constants and codes of the translation table walker.
package ptwt_pkg;

    localparam int MEM_AW    = 13;
    localparam int MEM_WORDS = 1 << MEM_AW;

    localparam int ADDR_W    = 48;
    localparam int VA_W      = 64;
    localparam int DESC_W    = 64;
    localparam int WIDX_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int SIZE_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_USER_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BASE = 2'd1;

    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_WRITE     = 1'b1;

    localparam logic [SIZE_W-1:0] PS_NONE = 2'd0;
    localparam logic [SIZE_W-1:0] PS_4K   = 2'd1;
    localparam logic [SIZE_W-1:0] PS_2M   = 2'd2;
    localparam logic [SIZE_W-1:0] PS_1G   = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WR,
        S_RD1,
        S_CHK1,
        S_CHK2,
        S_CHK3
    } t_state;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_ROOT,
        RD_L2,
        RD_L3
    } t_rd_sel;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_FAULT,
        RES_L1BLK,
        RES_L2BLK,
        RES_PAGE
    } t_res_kind;

    typedef struct packed {
        logic      load_item;
        logic      clr_step;
        logic      item_wr;
        t_rd_sel   rd_sel;
        logic      res_load;
        t_res_kind res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic desc_valid;
        logic desc_table;
        logic clr_done;
    } t_dp_stat;

endpackage

/* rtl/core/ptwt_ctrl.sv */
// Controller state machine that sequences clearing, writes and table walks.
module ptwt_ctrl
    import ptwt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_cmd,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy
);

    `include "page_table_walk_translate_top_assert.svh"

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.rd_sel   = RD_NONE;
        o_cmd.res_kind = RES_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load_item = 1'b1;
                    n_state = (i_cmd == CMD_WRITE) ? S_WR : S_RD1;
                end
            end
            S_WR: begin
                o_cmd.item_wr  = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = RES_NONE;
                n_state        = S_IDLE;
            end
            S_RD1: begin
                o_cmd.rd_sel = RD_ROOT;
                n_state      = S_CHK1;
            end
            S_CHK1: begin
                if (!i_stat.desc_valid) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_FAULT;
                    n_state        = S_IDLE;
                end else if (!i_stat.desc_table) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_L1BLK;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.rd_sel = RD_L2;
                    n_state      = S_CHK2;
                end
            end
            S_CHK2: begin
                if (!i_stat.desc_valid) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_FAULT;
                    n_state        = S_IDLE;
                end else if (!i_stat.desc_table) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_L2BLK;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.rd_sel = RD_L3;
                    n_state      = S_CHK3;
                end
            end
            S_CHK3: begin
                o_cmd.res_load = 1'b1;
                if (i_stat.desc_valid && i_stat.desc_table) begin
                    o_cmd.res_kind = RES_PAGE;
                end else begin
                    o_cmd.res_kind = RES_FAULT;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    `PTWT_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
    `PTWT_ASSERT_NEXT(a_result_returns_idle, o_cmd.res_load, r_state == S_IDLE)
    `PTWT_ASSERT_NEXT(a_clear_only_once, r_state != S_CLEAR, r_state != S_CLEAR)

endmodule

/* rtl/core/ptwt_dp.sv */
// Datapath with base registers, table memory, walk addressing and result registers.
module ptwt_dp
    import ptwt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    input  logic                 i_cmd,
    input  logic [VA_W-1:0]      i_virtual_address,
    input  logic [WIDX_W-1:0]    i_word_index,
    input  logic [DESC_W-1:0]    i_word_data,
    input  t_dp_cmd              i_dp_cmd,
    output t_dp_stat             o_stat,
    output logic [ADDR_W-1:0]    o_physical_address,
    output logic                 o_fault,
    output logic [SIZE_W-1:0]    o_page_size,
    output logic                 o_result_valid
);

    `include "page_table_walk_translate_top_assert.svh"

    logic [DESC_W-1:0] r_mem [MEM_WORDS];

    logic [ADDR_W-1:0] r_ubase;
    logic [ADDR_W-1:0] r_kbase;
    logic [VA_W-1:0]   r_va;
    logic [MEM_AW-1:0] r_widx;
    logic [DESC_W-1:0] r_wdata;
    logic [MEM_AW-1:0] r_clr_addr;
    logic [DESC_W-1:0] r_rdata;
    logic [ADDR_W-1:0] r_pa;
    logic              r_fault;
    logic [SIZE_W-1:0] r_size;
    logic              r_strobe;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [DESC_W-1:0] mem_wdata;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_raddr;
    logic [ADDR_W-1:0] root_base;
    logic [MEM_AW-1:0] next_base;
    logic [ADDR_W-1:0] n_pa;
    logic              n_fault;
    logic [SIZE_W-1:0] n_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ubase <= '0;
            r_kbase <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_USER_BASE) begin
                r_ubase <= i_cfg_wdata;
            end else if (i_cfg_addr == CFG_KERNEL_BASE) begin
                r_kbase <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_item) begin
            r_va    <= i_virtual_address;
            r_widx  <= MEM_AW'(i_word_index);
            r_wdata <= (i_cmd == CMD_WRITE) ? i_word_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_dp_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + MEM_AW'(1);
        end
    end

    assign mem_we    = i_dp_cmd.clr_step || i_dp_cmd.item_wr;
    assign mem_waddr = i_dp_cmd.clr_step ? r_clr_addr : r_widx;
    assign mem_wdata = i_dp_cmd.clr_step ? '0 : r_wdata;

    assign root_base = (r_va[63:48] != '0) ? r_kbase : r_ubase;
    assign next_base = MEM_AW'({r_rdata[47:12], 9'b0});
    assign mem_re    = (i_dp_cmd.rd_sel != RD_NONE);

    always_comb begin
        case (i_dp_cmd.rd_sel)
            RD_ROOT: mem_raddr = MEM_AW'(root_base[47:3]) + MEM_AW'(r_va[38:30]);
            RD_L2:   mem_raddr = next_base + MEM_AW'(r_va[29:21]);
            RD_L3:   mem_raddr = next_base + MEM_AW'(r_va[20:12]);
            default: mem_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign o_stat.desc_valid = r_rdata[0];
    assign o_stat.desc_table = r_rdata[1];
    assign o_stat.clr_done   = (r_clr_addr == '1);

    always_comb begin
        n_pa    = '0;
        n_fault = 1'b0;
        n_size  = PS_NONE;
        case (i_dp_cmd.res_kind)
            RES_NONE: begin
                n_pa = '0;
            end
            RES_FAULT: begin
                n_fault = 1'b1;
            end
            RES_L1BLK: begin
                n_pa   = {r_rdata[47:30], r_va[29:0]};
                n_size = PS_1G;
            end
            RES_L2BLK: begin
                n_pa   = {r_rdata[47:21], r_va[20:0]};
                n_size = PS_2M;
            end
            RES_PAGE: begin
                n_pa   = {r_rdata[47:12], r_va[11:0]};
                n_size = PS_4K;
            end
            default: begin
                n_pa = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.res_load) begin
            r_pa    <= n_pa;
            r_fault <= n_fault;
            r_size  <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_dp_cmd.res_load;
        end
    end

    assign o_physical_address = r_pa;
    assign o_fault            = r_fault;
    assign o_page_size        = r_size;
    assign o_result_valid     = r_strobe;

    `PTWT_ASSERT_SAME(a_fault_has_no_address, r_strobe && r_fault,
        (r_pa == '0) && (r_size == PS_NONE))
    `PTWT_ASSERT_SAME(a_no_size_no_address, r_strobe && (r_size == PS_NONE), r_pa == '0)
    `PTWT_ASSERT_SAME(a_no_read_while_writing, mem_we, !mem_re)

endmodule

/* rtl/core/page_table_walk_translate_top.sv */
// Top level of the three-level translation table walker with a 4 KB granule.
// After reset the block clears its 8192-word table memory, one word per cycle, and holds
// busy high for that whole pass; configuration writes are taken during that pass. An item
// is accepted when start is high and busy is low. Its single result beat appears on the
// result ports for one cycle with o_result_valid high; the receiver cannot stall, so it must
// capture the beat in that cycle. A new item can be started once busy falls: a write item
// passes through S_WR, a translation through S_RD1 and one check state per level reached
// (level one ends in a 1 GB block or fault). The walk length is set by the chain of
// dependent table memory reads on the single registered read port, one read per level.
// The result beat of an item may overlap the acceptance of the next one.
module page_table_walk_translate_top
    import ptwt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cmd,
    input  logic [VA_W-1:0]      i_virtual_address,
    input  logic [WIDX_W-1:0]    i_word_index,
    input  logic [DESC_W-1:0]    i_word_data,
    output logic                 o_result_valid,
    output logic [ADDR_W-1:0]    o_physical_address,
    output logic                 o_fault,
    output logic [SIZE_W-1:0]    o_page_size
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ptwt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy)
    );

    ptwt_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_cmd              (i_cmd),
        .i_virtual_address  (i_virtual_address),
        .i_word_index       (i_word_index),
        .i_word_data        (i_word_data),
        .i_dp_cmd           (dp_cmd),
        .o_stat             (dp_stat),
        .o_physical_address (o_physical_address),
        .o_fault            (o_fault),
        .o_page_size        (o_page_size),
        .o_result_valid     (o_result_valid)
    );

endmodule
